@@ rtl/core/btc_pkg.sv @@
// ============================================================================
// btc_pkg
// Shared widths, reset values and register addresses of the transitive
// closure block.
// ============================================================================
package btc_pkg;

    localparam int ROW_W                = 64;  // adjacency row width
    localparam int ROW_NUM_W            = 6;   // emitted row index width
    localparam int VC_W                 = 7;   // vertex count register width
    localparam int MAX_VERTICES_DEFAULT = 64;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [VC_W-1:0]       VC_RESET          = 7'd64;
    localparam logic [APB_ADDR_W-1:0] ADDR_VERTEX_COUNT = 3'd0;

endpackage

@@ rtl/core/btc_row_in_if.sv @@
// ============================================================================
// btc_row_in_if
// Input channel: one adjacency row per item, valid/ready handshake.
// ============================================================================
interface btc_row_in_if;

    logic                          valid;
    logic                          ready;
    logic [btc_pkg::ROW_W-1:0]     row_bits;
    logic                          last_row;

    modport source (output valid, output row_bits, output last_row, input ready);
    modport sink   (input valid, input row_bits, input last_row, output ready);

endinterface

@@ rtl/core/btc_row_out_if.sv @@
// ============================================================================
// btc_row_out_if
// Output channel: one closed row per item, valid/ready handshake.
// ============================================================================
interface btc_row_out_if;

    logic                              valid;
    logic                              ready;
    logic [btc_pkg::ROW_W-1:0]         closure_bits;
    logic [btc_pkg::ROW_NUM_W-1:0]     row_number;
    logic                              final_row;

    modport source (output valid, output closure_bits, output row_number,
                    output final_row, input ready);
    modport sink   (input valid, input closure_bits, input row_number,
                    input final_row, output ready);

endinterface

@@ rtl/core/btc_ram.sv @@
// ============================================================================
// btc_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ============================================================================
module btc_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/core/boolean_transitive_closure.sv @@
// ============================================================================
// boolean_transitive_closure
// Reflexive transitive closure (Warshall) of a boolean adjacency matrix.
// ============================================================================
// Rows arrive one item per cycle while loading, from row 0 up; each is
// masked to the active vertex count N and gets its diagonal bit set. A row
// marked last_row, or the row at index N-1, ends the load; rows never loaded
// are filled with their diagonal only, one per cycle. The closure then runs
// pivot k = 0..N-1: for each pivot, row k is read and latched, then every
// row is read, updated and written back through the single matrix RAM port
// pair. Closed rows leave in order, with final_row on row N-1; each row is
// read and then captured into the output register, and the next read waits
// until that register is free. Input rows are accepted only while loading;
// the next matrix may start loading while the final closed row still waits
// in the output register. vertex_count (APB offset 0) may be changed only
// while the block is idle; 0 acts as 1 and values above MAX_VERTICES act as
// MAX_VERTICES.
// ============================================================================
module boolean_transitive_closure #(
    parameter int MAX_VERTICES = btc_pkg::MAX_VERTICES_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    btc_row_in_if.sink                      load,
    btc_row_out_if.source                   emit,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [btc_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [btc_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [btc_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int NW = AW + 1;   // holds a count up to MAX_VERTICES
    localparam int RW = btc_pkg::ROW_W;

    typedef enum logic [2:0] {
        S_LOAD,
        S_FILL,
        S_PIV,
        S_LATCH,
        S_SWEEP,
        S_EMIT_RD,
        S_EMIT_CAP
    } state_t;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t                        state_reg, state_next;
    logic [btc_pkg::VC_W-1:0]      vc_reg, vc_next;
    logic [AW-1:0]                 idx_reg, idx_next;    // next row to load
    logic [AW-1:0]                 row_reg, row_next;    // fill/sweep/emit row
    logic [AW-1:0]                 piv_reg, piv_next;    // pivot index k
    logic [RW-1:0]                 pivot_reg, pivot_next;
    logic                          ovalid_reg, ovalid_next;
    logic [RW-1:0]                 obits_reg, obits_next;
    logic [btc_pkg::ROW_NUM_W-1:0] onum_reg, onum_next;
    logic                          ofinal_reg, ofinal_next;

    // ------------------------------------------------------------------
    // Matrix RAM
    // ------------------------------------------------------------------
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [RW-1:0] ram_wdata, ram_rdata;

    btc_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_VERTICES)
    ) u_matrix (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Effective vertex count and column mask
    // ------------------------------------------------------------------
    logic [NW-1:0] n_eff;
    logic [RW-1:0] col_mask;

    always_comb
    begin
        if (vc_reg == '0)
            n_eff = NW'(1);
        else if (vc_reg > btc_pkg::VC_W'(MAX_VERTICES))
            n_eff = NW'(MAX_VERTICES);
        else
            n_eff = NW'(vc_reg);
    end

    always_comb
    begin
        for (int j = 0; j < RW; j++)
        begin
            col_mask[j] = (j < int'(n_eff));
        end
    end

    // Row index plus one, compared against N for "last row" decisions
    logic [NW-1:0] idx_inc, row_inc, piv_inc;
    logic          idx_done, row_last, piv_last, idx_in_range;

    assign idx_inc      = {1'b0, idx_reg} + NW'(1);
    assign row_inc      = {1'b0, row_reg} + NW'(1);
    assign piv_inc      = {1'b0, piv_reg} + NW'(1);
    assign idx_in_range = ({1'b0, idx_reg} < n_eff);
    assign idx_done     = (idx_inc >= n_eff);
    assign row_last     = (row_inc >= n_eff);
    assign piv_last     = (piv_inc >= n_eff);

    logic load_fire, out_free;
    assign load_fire = load.valid && load.ready;
    assign out_free  = !ovalid_reg || emit.ready;

    // ------------------------------------------------------------------
    // Handshake and APB outputs
    // ------------------------------------------------------------------
    assign load.ready        = (state_reg == S_LOAD);
    assign emit.valid        = ovalid_reg;
    assign emit.closure_bits = obits_reg;
    assign emit.row_number   = onum_reg;
    assign emit.final_row    = ofinal_reg;

    assign pready = 1'b1;
    assign prdata = (paddr == btc_pkg::ADDR_VERTEX_COUNT)
                  ? btc_pkg::APB_DATA_W'(vc_reg) : '0;

    // ------------------------------------------------------------------
    // Next state, RAM access
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next  = state_reg;
        vc_next     = vc_reg;
        idx_next    = idx_reg;
        row_next    = row_reg;
        piv_next    = piv_reg;
        pivot_next  = pivot_reg;
        ovalid_next = ovalid_reg;
        obits_next  = obits_reg;
        onum_next   = onum_reg;
        ofinal_next = ofinal_reg;

        ram_we    = 1'b0;
        ram_waddr = row_reg;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        ram_raddr = row_reg;

        // Drop the output item once the sink takes it
        if (ovalid_reg && emit.ready)
            ovalid_next = 1'b0;

        if (psel && penable && pwrite && pready
            && paddr == btc_pkg::ADDR_VERTEX_COUNT)
            vc_next = pwdata[btc_pkg::VC_W-1:0];

        unique case (state_reg)
            S_LOAD:
            begin
                if (load_fire)
                begin
                    // Store masked row with its diagonal; rows past N are dropped
                    ram_we    = idx_in_range;
                    ram_waddr = idx_reg;
                    ram_wdata = (load.row_bits & col_mask)
                              | (RW'(1) << idx_reg);
                    if (load.last_row || idx_done)
                    begin
                        idx_next = '0;
                        piv_next = '0;
                        if (idx_inc < n_eff)
                        begin
                            row_next   = AW'(idx_inc);
                            state_next = S_FILL;
                        end
                        else
                        begin
                            state_next = S_PIV;
                        end
                    end
                    else
                    begin
                        idx_next = AW'(idx_inc);
                    end
                end
            end

            S_FILL:
            begin
                // Rows missing from a short matrix hold only their diagonal
                ram_we    = 1'b1;
                ram_waddr = row_reg;
                ram_wdata = RW'(1) << row_reg;
                if (row_last)
                    state_next = S_PIV;
                else
                    row_next = AW'(row_inc);
            end

            S_PIV:
            begin
                ram_re     = 1'b1;
                ram_raddr  = piv_reg;
                state_next = S_LATCH;
            end

            S_LATCH:
            begin
                // Hold pivot row, start the sweep at row 0
                pivot_next = ram_rdata;
                ram_re     = 1'b1;
                ram_raddr  = '0;
                row_next   = '0;
                state_next = S_SWEEP;
            end

            S_SWEEP:
            begin
                // Write back the row read last cycle, read the next one
                ram_we    = 1'b1;
                ram_waddr = row_reg;
                ram_wdata = ram_rdata[btc_pkg::ROW_NUM_W'(piv_reg)]
                          ? (ram_rdata | pivot_reg) : ram_rdata;
                ram_re    = !row_last;
                ram_raddr = AW'(row_inc);
                if (row_last)
                begin
                    row_next = '0;
                    if (piv_last)
                    begin
                        state_next = S_EMIT_RD;
                    end
                    else
                    begin
                        piv_next   = AW'(piv_inc);
                        state_next = S_PIV;
                    end
                end
                else
                begin
                    row_next = AW'(row_inc);
                end
            end

            S_EMIT_RD:
            begin
                // Read the next row only when the output register frees up
                if (out_free)
                begin
                    ram_re     = 1'b1;
                    ram_raddr  = row_reg;
                    state_next = S_EMIT_CAP;
                end
            end

            S_EMIT_CAP:
            begin
                ovalid_next = 1'b1;
                obits_next  = ram_rdata & col_mask;
                onum_next   = btc_pkg::ROW_NUM_W'(row_reg);
                ofinal_next = row_last;
                if (row_last)
                begin
                    row_next   = '0;
                    state_next = S_LOAD;
                end
                else
                begin
                    row_next   = AW'(row_inc);
                    state_next = S_EMIT_RD;
                end
            end

            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // State and registered outputs
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_LOAD;
            vc_reg     <= btc_pkg::VC_RESET;
            idx_reg    <= '0;
            row_reg    <= '0;
            piv_reg    <= '0;
            pivot_reg  <= '0;
            ovalid_reg <= 1'b0;
            obits_reg  <= '0;
            onum_reg   <= '0;
            ofinal_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            vc_reg     <= vc_next;
            idx_reg    <= idx_next;
            row_reg    <= row_next;
            piv_reg    <= piv_next;
            pivot_reg  <= pivot_next;
            ovalid_reg <= ovalid_next;
            obits_reg  <= obits_next;
            onum_reg   <= onum_next;
            ofinal_reg <= ofinal_next;
        end
    end

endmodule
